// ----- rtl/tle_pkg.sv -----
package tle_pkg;

  localparam int BufferBytes = 64;
  localparam int StoreDepth  = 64;
  localparam int AddrW       = $clog2(StoreDepth);
  localparam int LenW        = AddrW;
  localparam int CapRaw      = (BufferBytes > 1) ? BufferBytes - 1 : 0;
  localparam int Capacity    = (CapRaw > StoreDepth - 1) ? StoreDepth - 1 : CapRaw;
  localparam int PromptLen   = 9;
  localparam int RuboutLen   = 3;

  localparam logic [7:0] KeyCr   = 8'h0D;
  localparam logic [7:0] KeyLf   = 8'h0A;
  localparam logic [7:0] KeyBs   = 8'h08;
  localparam logic [7:0] KeyDel  = 8'h7F;
  localparam logic [7:0] KeyBell = 8'h07;
  localparam logic [7:0] KeySp   = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ECHO,
    ST_RUBOUT,
    ST_LINE
  } tle_state_e;

  typedef enum logic [1:0] {
    KIND_ECHO,
    KIND_RUBOUT,
    KIND_LINE
  } tle_kind_e;

  typedef struct packed {
    logic      accept;
    logic      emit;
    tle_kind_e kind;
  } tle_cmd_t;

  typedef struct packed {
    logic is_cr;
    logic is_bs;
    logic len_zero;
    logic out_free;
    logic seq_last;
  } tle_status_t;

  // CR LF CR LF "i2c> "
  function automatic logic [7:0] prompt_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = KeyCr;
      4'd1:    b = KeyLf;
      4'd2:    b = KeyCr;
      4'd3:    b = KeyLf;
      4'd4:    b = 8'h69;
      4'd5:    b = 8'h32;
      4'd6:    b = 8'h63;
      4'd7:    b = 8'h3E;
      4'd8:    b = KeySp;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // back-space, space, back-space
  function automatic logic [7:0] rubout_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = KeyBs;
      2'd1:    b = KeySp;
      2'd2:    b = KeyBs;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/terminal_line_editor_unit.sv -----
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o | rx_byte_i
// out     | output    | out_valid_o/out_stall_i | tx_valid_o tx_byte_o line_valid_o
//         |           |                      | line_byte_o line_end_o last_o
//
// One input word is taken in the idle state; the sequencer then emits its
// result words one per cycle while the output is not stalled, into the
// output register: 1 for a plain byte, 3 for a rubout, max(length, 9) for
// carriage return.
// Line readout rate is set by the single registered read port of the store.
// Reset clears the length count and the sequencer; the store is not cleared.
// Output stall freezes the sequencer; input stays stalled until the item's
// last result word has been loaded.
module terminal_line_editor_unit import tle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       line_valid_o,
  output logic [7:0] line_byte_o,
  output logic       line_end_o,
  output logic       last_o
);

  tle_cmd_t    cmd;
  tle_status_t status;

  tle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tle_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tx_valid_o   (tx_valid_o),
    .tx_byte_o    (tx_byte_o),
    .line_valid_o (line_valid_o),
    .line_byte_o  (line_byte_o),
    .line_end_o   (line_end_o),
    .last_o       (last_o)
  );

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("result emitted into a full output register");

  a_no_emit_when_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !cmd.emit)
    else $error("sequencer emitting while input is open");

  a_word_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tx_valid_o || line_valid_o))
    else $error("result word carries neither terminal nor line byte");

  a_end_on_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_end_o |-> line_valid_o)
    else $error("line end flagged without a line byte");

endmodule

// ----- rtl/tle_ctrl.sv -----
module tle_ctrl import tle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  tle_status_t status_i,
  output tle_cmd_t    cmd_o
);

  tle_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.is_cr) begin
            state_d = ST_LINE;
          end else if (status_i.is_bs) begin
            state_d = status_i.len_zero ? ST_IDLE : ST_RUBOUT;
          end else begin
            state_d = ST_ECHO;
          end
        end
      end
      ST_ECHO, ST_RUBOUT, ST_LINE: begin
        if (status_i.out_free && status_i.seq_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    cmd_o.kind  = KIND_ECHO;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_ECHO: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.kind = KIND_ECHO;
      end
      ST_RUBOUT: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.kind = KIND_RUBOUT;
      end
      ST_LINE: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.kind = KIND_LINE;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/tle_dp.sv -----
module tle_dp import tle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  rx_byte_i,
  input  tle_cmd_t    cmd_i,
  output tle_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        line_valid_o,
  output logic [7:0]  line_byte_o,
  output logic        line_end_o,
  output logic        last_o
);

  logic [7:0]      mem [StoreDepth];
  logic [7:0]      rd_q;
  logic [AddrW-1:0] rd_addr;

  logic [LenW-1:0] len_q, len_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] idx_inc;
  logic [LenW-1:0] seq_len;
  logic [7:0]      byte_q;
  logic            bell_q;

  logic            out_valid_q;
  logic            tx_valid_q, line_valid_q, line_end_q, last_q;
  logic [7:0]      tx_byte_q, line_byte_q;

  logic            is_cr, is_bs, len_zero, len_full, store_en, seq_last;
  logic            tx_ok, ln_ok;
  logic            r_tx_valid, r_line_valid, r_line_end;
  logic [7:0]      r_tx_byte, r_line_byte;

  assign is_cr    = (rx_byte_i == KeyCr);
  assign is_bs    = (rx_byte_i == KeyBs) || (rx_byte_i == KeyDel);
  assign len_zero = (len_q == '0);
  assign len_full = (len_q >= LenW'(Capacity));
  assign store_en = !is_cr && !is_bs && !len_full;

  assign idx_inc = idx_q + AddrW'(1);
  assign seq_len = (len_q > LenW'(PromptLen)) ? len_q : LenW'(PromptLen);

  always_comb begin
    case (cmd_i.kind)
      KIND_ECHO:   seq_last = 1'b1;
      KIND_RUBOUT: seq_last = (idx_inc == AddrW'(RuboutLen));
      KIND_LINE:   seq_last = (idx_inc == seq_len);
      default:     seq_last = 1'b1;
    endcase
  end

  // line store: read port walks ahead so rd_q holds entry idx_q during line emission
  assign rd_addr = (cmd_i.emit && cmd_i.kind == KIND_LINE) ? idx_inc : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && store_en) begin
      mem[len_q] <= rx_byte_i;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    len_d = len_q;
    if (cmd_i.accept) begin
      if (is_bs && !is_cr) begin
        if (!len_zero) len_d = len_q - LenW'(1);
      end else if (store_en) begin
        len_d = len_q + LenW'(1);
      end
    end else if (cmd_i.emit && cmd_i.kind == KIND_LINE && seq_last) begin
      len_d = '0;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.emit) begin
      idx_d = seq_last ? '0 : idx_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      idx_q <= '0;
    end else begin
      len_q <= len_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= rx_byte_i;
      bell_q <= len_full;
    end
  end

  // result word for the current sequence step
  assign tx_ok = (idx_q < AddrW'(PromptLen));
  assign ln_ok = (idx_q < len_q);

  always_comb begin
    r_tx_valid   = 1'b1;
    r_tx_byte    = 8'h00;
    r_line_valid = 1'b0;
    r_line_byte  = 8'h00;
    r_line_end   = 1'b0;
    case (cmd_i.kind)
      KIND_ECHO: begin
        r_tx_byte = bell_q ? KeyBell : byte_q;
      end
      KIND_RUBOUT: begin
        r_tx_byte = rubout_byte(idx_q[1:0]);
      end
      KIND_LINE: begin
        r_tx_valid   = tx_ok;
        r_tx_byte    = tx_ok ? prompt_byte(idx_q[3:0]) : 8'h00;
        r_line_valid = ln_ok;
        r_line_byte  = ln_ok ? rd_q : 8'h00;
        r_line_end   = ln_ok && (idx_inc == len_q);
      end
      default: begin
        r_tx_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      tx_valid_q   <= r_tx_valid;
      tx_byte_q    <= r_tx_byte;
      line_valid_q <= r_line_valid;
      line_byte_q  <= r_line_byte;
      line_end_q   <= r_line_end;
      last_q       <= seq_last;
    end
  end

  assign status_o.is_cr    = is_cr;
  assign status_o.is_bs    = is_bs;
  assign status_o.len_zero = len_zero;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.seq_last = seq_last;

  assign out_valid_o  = out_valid_q;
  assign tx_valid_o   = tx_valid_q;
  assign tx_byte_o    = tx_byte_q;
  assign line_valid_o = line_valid_q;
  assign line_byte_o  = line_byte_q;
  assign line_end_o   = line_end_q;
  assign last_o       = last_q;

endmodule
